>>> rtl/core/packet_deframer_checksum_assert.svh
// assertion macros for the deframer rtl
`ifndef PACKET_DEFRAMER_CHECKSUM_ASSERT_SVH
`define PACKET_DEFRAMER_CHECKSUM_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define PDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pdc_pkg.sv
// shared types and constants of the packet deframer
`timescale 1ns / 1ps
package pdc_pkg;

  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 8;
  localparam int PHASE_W   = 2;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd42;  // '*'
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd64;  // '@'
  localparam logic [BYTE_W-1:0] MIN_FRAME_LEN     = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;

  localparam logic [PHASE_W-1:0] PH_HUNT  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HEAD2 = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LEN   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_BODY  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GOOD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload_size;
    logic              last;
  } result_t;

endpackage

>>> rtl/core/pdc_cfg.sv
// header byte configuration registers
`timescale 1ns / 1ps
module pdc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdc_pkg::BYTE_W-1:0]    cfg_data,
  output pdc_pkg::cfg_t                 cfg
);

  pdc_pkg::cfg_t cfg_r;
  pdc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        pdc_pkg::REG_HEADER_FIRST:  cfg_nxt.header_first  = cfg_data;
        pdc_pkg::REG_HEADER_SECOND: cfg_nxt.header_second = cfg_data;
        default: cfg_nxt = cfg_r;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= pdc_pkg::HEADER_FIRST_RST;
      cfg_r.header_second <= pdc_pkg::HEADER_SECOND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/core/pdc_parse.sv
// input word register and frame parser state
`timescale 1ns / 1ps
`include "packet_deframer_checksum_assert.svh"
module pdc_parse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [pdc_pkg::BYTE_W-1:0] in_byte,
  input  pdc_pkg::cfg_t              cfg,
  input  logic                       out_free,
  output logic                       res_valid,
  output pdc_pkg::result_t           res
);

  logic                        in_valid_r, in_valid_nxt;
  logic [pdc_pkg::BYTE_W-1:0]  in_byte_r;
  logic [pdc_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [pdc_pkg::BYTE_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [pdc_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [pdc_pkg::BYTE_W-1:0]  frame_len_r, frame_len_nxt;
  logic                        seen_cmd_r, seen_cmd_nxt;
  logic                        fire;
  logic [pdc_pkg::BYTE_W-1:0]  left_dec;
  logic [pdc_pkg::BYTE_W-1:0]  sum_add;

  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || fire;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  assign left_dec = bytes_left_r - 8'd1;
  assign sum_add  = sum_r + in_byte_r;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    sum_nxt        = sum_r;
    frame_len_nxt  = frame_len_r;
    seen_cmd_nxt   = seen_cmd_r;
    res_valid      = 1'b0;
    res.out_byte     = in_byte_r;
    res.kind         = seen_cmd_r ? pdc_pkg::KIND_DATA : pdc_pkg::KIND_CMD;
    res.payload_size = '0;
    res.last         = 1'b0;
    if (fire) begin
      case (phase_r)
        pdc_pkg::PH_HUNT: begin
          if (in_byte_r == cfg.header_first) phase_nxt = pdc_pkg::PH_HEAD2;
        end
        pdc_pkg::PH_HEAD2: begin
          // a wrong second byte may itself open a new frame
          if (in_byte_r == cfg.header_second) phase_nxt = pdc_pkg::PH_LEN;
          else if (in_byte_r == cfg.header_first) phase_nxt = pdc_pkg::PH_HEAD2;
          else phase_nxt = pdc_pkg::PH_HUNT;
        end
        pdc_pkg::PH_LEN: begin
          if (in_byte_r >= pdc_pkg::MIN_FRAME_LEN) begin
            phase_nxt      = pdc_pkg::PH_BODY;
            bytes_left_nxt = in_byte_r - 8'd1;
            sum_nxt        = in_byte_r;
            frame_len_nxt  = in_byte_r;
            seen_cmd_nxt   = 1'b0;
          end else begin
            phase_nxt = pdc_pkg::PH_HUNT;
          end
        end
        pdc_pkg::PH_BODY: begin
          bytes_left_nxt = left_dec;
          sum_nxt        = sum_add;
          res_valid      = 1'b1;
          if (left_dec == '0) begin
            res.kind = (sum_add == '0) ? pdc_pkg::KIND_GOOD : pdc_pkg::KIND_BAD;
            res.payload_size = frame_len_r - pdc_pkg::MIN_FRAME_LEN;
            res.last         = 1'b1;
            phase_nxt        = pdc_pkg::PH_HUNT;
          end else begin
            seen_cmd_nxt = 1'b1;
          end
        end
        default: phase_nxt = pdc_pkg::PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_byte_r <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      phase_r      <= pdc_pkg::PH_HUNT;
      bytes_left_r <= '0;
      sum_r        <= '0;
      frame_len_r  <= '0;
      seen_cmd_r   <= 1'b0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_r        <= sum_nxt;
      frame_len_r  <= frame_len_nxt;
      seen_cmd_r   <= seen_cmd_nxt;
    end
  end

  `PDC_ASSERT_NOW(a_body_count_live, clk, rst_n, phase_r == pdc_pkg::PH_BODY, bytes_left_r != '0, "body phase with no bytes left")
  `PDC_ASSERT_NOW(a_end_kind, clk, rst_n, res_valid && res.last, res.kind == pdc_pkg::KIND_GOOD || res.kind == pdc_pkg::KIND_BAD, "end word without verdict")
  `PDC_ASSERT_NOW(a_mid_size_zero, clk, rst_n, res_valid && !res.last, res.payload_size == '0 && res.kind != pdc_pkg::KIND_GOOD && res.kind != pdc_pkg::KIND_BAD, "body word with end fields")
  `PDC_ASSERT_NEXT(a_end_rehunt, clk, rst_n, res_valid && res.last, phase_r == pdc_pkg::PH_HUNT, "no return to hunting after end word")
  `PDC_ASSERT_NOW(a_result_has_room, clk, rst_n, res_valid, out_free, "result produced with output slot busy")

endmodule

>>> rtl/core/pdc_out.sv
// result register toward the output stream
`timescale 1ns / 1ps
module pdc_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  pdc_pkg::result_t res,
  output logic             out_free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output pdc_pkg::result_t out_res
);

  logic             out_valid_r, out_valid_nxt;
  pdc_pkg::result_t res_r;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) res_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/packet_deframer_checksum.sv
// top level of the packet deframer with checksum check
`timescale 1ns / 1ps
// Finds frames in a received byte stream: two header bytes (set by the header_first
// and header_second registers, reset '*' and '@'), a length byte L of 3 or more, a
// command byte, L-3 data bytes and a checksum byte. Command and data bytes come out
// one word each as they arrive; the checksum byte closes the frame with a word that
// has tlast set, the payload size and a good/bad verdict (good when the 8-bit sum
// from the length byte through the checksum is zero). Header and length bytes give
// no output; a short length drops the frame. The block takes one byte per cycle
// while the output is not stalled: each byte passes an input register, the parser
// logic (a compare and an 8-bit add) and a result register that drives the output.
// in_tready drops only while a byte is held, a result is waiting and out_tready is
// low, whatever the held byte is. Configuration writes are always accepted and
// should be done while no frame is in flight.
module packet_deframer_checksum (
  input  logic        clk,
  input  logic        rst_n,
  // received bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // deframed words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [15:8] payload_size
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // end of frame
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,  // 0 header_first, 1 header_second
  input  logic [7:0]  cfg_data
);

  pdc_pkg::cfg_t    cfg;        // current header bytes
  pdc_pkg::result_t res;        // parser result of this cycle
  pdc_pkg::result_t out_res;    // registered result
  logic             res_valid;
  logic             out_free;   // result register can take a word now

  // header byte registers
  pdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register plus frame state machine
  pdc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .cfg       (cfg),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  pdc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // pack result fields onto the stream
  assign out_tdata = {out_res.payload_size, out_res.out_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

>>> dv/pdc_stream_checker.sv
// stream checker for the packet deframer: predicts every output word and compares
`timescale 1ns / 1ps
module pdc_stream_checker
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          words_pending,
  output int          words_checked,
  output int          frames_good,
  output int          frames_bad,
  output logic        hunting
);

  localparam int REPORT_CAP = 200;

  result_t              deframed_q[$];
  logic [BYTE_W-1:0]    hdr_first, hdr_second;
  logic [PHASE_W-1:0]   phase;
  logic [BYTE_W-1:0]    body_left, frame_sum, frame_len;
  logic                 cmd_done;

  // advance the parser by one received byte, queue the word it should give
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    result_t w;
    case (phase)
      PH_HUNT: begin
        if (b == hdr_first) phase = PH_HEAD2;
      end
      PH_HEAD2: begin
        if (b == hdr_second) phase = PH_LEN;
        else if (b == hdr_first) phase = PH_HEAD2;
        else phase = PH_HUNT;
      end
      PH_LEN: begin
        if (b >= MIN_FRAME_LEN) begin
          phase     = PH_BODY;
          body_left = b - 8'd1;
          frame_sum = b;
          frame_len = b;
          cmd_done  = 1'b0;
        end else begin
          phase = PH_HUNT;
        end
      end
      default: begin
        body_left  = body_left - 8'd1;
        frame_sum  = frame_sum + b;
        w.out_byte = b;
        if (body_left == 8'd0) begin
          w.kind         = (frame_sum == 8'd0) ? KIND_GOOD : KIND_BAD;
          w.payload_size = frame_len - MIN_FRAME_LEN;
          w.last         = 1'b1;
          phase          = PH_HUNT;
          if (w.kind == KIND_GOOD) frames_good++;
          else frames_bad++;
        end else begin
          w.kind         = cmd_done ? KIND_DATA : KIND_CMD;
          w.payload_size = 8'd0;
          w.last         = 1'b0;
          cmd_done       = 1'b1;
        end
        deframed_q.push_back(w);
      end
    endcase
  endtask

  task automatic check_word();
    result_t want;
    words_checked++;
    if (deframed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: unexpected word: expected none, got byte %02h kind %0d size %0d last %0b",
                 $time, out_tdata[7:0], out_tuser, out_tdata[15:8], out_tlast);
    end else begin
      want = deframed_q.pop_front();
      if (out_tdata[7:0] !== want.out_byte || out_tdata[15:8] !== want.payload_size ||
          out_tuser !== want.kind || out_tlast !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: expected byte %02h kind %0d size %0d last %0b, got byte %02h kind %0d size %0d last %0b",
                   $time, want.out_byte, want.kind, want.payload_size, want.last,
                   out_tdata[7:0], out_tuser, out_tdata[15:8], out_tlast);
      end
    end
    if (mismatches == REPORT_CAP + 1)
      $display("%0t: further errors are counted without detail", $time);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      deframed_q.delete();
      hdr_first     = HEADER_FIRST_RST;
      hdr_second    = HEADER_SECOND_RST;
      phase         = PH_HUNT;
      body_left     = 8'd0;
      frame_sum     = 8'd0;
      frame_len     = 8'd0;
      cmd_done      = 1'b0;
      mismatches    = 0;
      words_checked = 0;
      frames_good   = 0;
      frames_bad    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEADER_FIRST) hdr_first = cfg_data;
        else if (cfg_index == REG_HEADER_SECOND) hdr_second = cfg_data;
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (out_tvalid === 1'b1 && out_tready) check_word();
    end
    words_pending = deframed_q.size();
    hunting       = (phase == PH_HUNT);
  end

endmodule

>>> dv/tb.sv
// top of the deframer testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import pdc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;   // pipeline is two deep, leave some slack
  // index past the register list, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  int   mismatches, words_pending, words_checked, frames_good, frames_bad;
  logic hunting;

  // our own copy of the header registers, used to build frames
  logic [7:0] hdr1, hdr2;
  int bytes_sent = 0;
  int cycles     = 0;
  int gap_pct    = 0;   // chance of a sender gap burst before a byte
  int stall_pct  = 0;   // chance of a receiver stall burst per cycle
  int stall_left = 0;

  packet_deframer_checksum uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pdc_stream_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .words_pending (words_pending),
    .words_checked (words_checked),
    .frames_good   (frames_good),
    .frames_bad    (frames_bad),
    .hunting       (hunting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver back-pressure: stall bursts of random length
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("packet_deframer_checksum: mismatch");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  // with in_tvalid still high, so the caller either sends again or drops it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap       = $urandom_range(1, 5);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // header, length, command, data, checksum (good or random)
  task automatic send_frame(input logic [7:0] len, input bit good);
    logic [7:0] sum, b;
    int k;
    send_byte(hdr1);
    send_byte(hdr2);
    send_byte(len);
    sum = len;
    for (k = 0; k < int'(len) - 2; k++) begin
      b   = 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    b = good ? 8'd0 - sum : 8'($urandom);
    send_byte(b);
  endtask

  // feed filler until the parser hunts again, then wait for all words to drain
  task automatic drain_to_idle();
    logic [7:0] fill;
    fill = 8'd0;
    while (fill == hdr1 || fill == hdr2) fill++;
    while (!hunting) send_byte(fill);
    in_tvalid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_HEADER_FIRST) hdr1 = val;
    else if (idx == REG_HEADER_SECOND) hdr2 = val;
  endtask

  // new header pair, written only with the block drained
  task automatic set_headers(input logic [7:0] h1, input logic [7:0] h2);
    drain_to_idle();
    write_reg(REG_HEADER_FIRST, h1);
    write_reg(REG_SPARE, 8'($urandom));
    write_reg(REG_HEADER_SECOND, h2);
  endtask

  // mostly well-formed frames, plus noise and broken headers
  task automatic random_traffic(input int count, input bit calm);
    int stop_at, pick, n, k;
    logic [7:0] len;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if (calm) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 29) == 0) begin
        // switch between busy stretches and stretches with bursts
        gap_pct   = $urandom_range(0, 1) ? 20 : 0;
        stall_pct = $urandom_range(0, 1) ? 20 : 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = $urandom_range(0, 79);
        if (n == 0) len = 8'd255;
        else if (n < 3) len = 8'($urandom_range(13, 64));
        else len = 8'($urandom_range(3, 12));
        send_frame(len, $urandom_range(0, 3) != 0);
      end else if (pick < 80) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) send_byte(8'($urandom));
      end else if (pick < 85) begin
        // length below three drops the frame
        send_byte(hdr1);
        send_byte(hdr2);
        send_byte(8'($urandom_range(0, 2)));
      end else if (pick < 92) begin
        // wrong second header byte, sometimes a repeated first header byte
        send_byte(hdr1);
        send_byte($urandom_range(0, 1) ? hdr1 : 8'($urandom));
      end else begin
        // header-like bytes in random order
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) send_byte($urandom_range(0, 1) ? hdr1 : hdr2);
      end
    end
  endtask

  initial begin
    logic [7:0] opening [20];
    int i;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    cfg_valid = 1'b0;
    cfg_index = REG_HEADER_FIRST;
    cfg_data  = 8'd0;
    hdr1      = HEADER_FIRST_RST;
    hdr2      = HEADER_SECOND_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed opening with reset headers:
    // repeated first header then shortest good frame, two dropped short lengths,
    // a bad frame with 8'hff/8'h00 body, then stray bytes
    opening = '{HEADER_FIRST_RST, HEADER_FIRST_RST, HEADER_SECOND_RST, 8'd3, 8'h05, 8'hf8,
                HEADER_FIRST_RST, HEADER_SECOND_RST, 8'd2,
                HEADER_FIRST_RST, HEADER_SECOND_RST, 8'd0,
                HEADER_FIRST_RST, HEADER_SECOND_RST, 8'd4, 8'hff, 8'h00, 8'h00,
                8'hff, 8'h00};
    for (i = 0; i < 20; i++) send_byte(opening[i]);

    // header extremes, equal headers, random pair, then back to reset values
    set_headers(8'h00, 8'hff);
    random_traffic(330, 1'b0);
    set_headers(8'hff, 8'h00);
    random_traffic(330, 1'b0);
    set_headers(8'h55, 8'h55);
    random_traffic(330, 1'b0);
    set_headers(8'($urandom), 8'($urandom));
    random_traffic(330, 1'b0);
    set_headers(HEADER_FIRST_RST, HEADER_SECOND_RST);
    random_traffic(330, 1'b1);
    drain_to_idle();

    $display("sent %0d bytes over five header settings", bytes_sent);
    $display("%0d words checked, %0d good and %0d bad frames",
             words_checked, frames_good, frames_bad);
    if (mismatches == 0 && words_pending == 0) begin
      $display("packet_deframer_checksum: match");
    end else begin
      $display("packet_deframer_checksum: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pdc_pkg.sv
rtl/core/pdc_cfg.sv
rtl/core/pdc_parse.sv
rtl/core/pdc_out.sv
rtl/core/packet_deframer_checksum.sv
dv/pdc_stream_checker.sv
dv/tb.sv
